[rtl/keyframe_segment_locate_unit_macros.svh]
// assertion helpers shared by the keyframe locate modules
`ifndef KEYFRAME_SEGMENT_LOCATE_UNIT_MACROS_SVH
`define KEYFRAME_SEGMENT_LOCATE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define KSL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyframe locate check failed");

// next-cycle implication, checked outside reset
`define KSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyframe locate check failed");

`endif

[rtl/ksl_pkg.sv]
package ksl_pkg;

  // field widths of the stream payloads
  localparam int unsigned KeyIdxW   = 6;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned CountW    = 7;
  localparam int unsigned AlphaW    = 16;
  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 32;
  localparam int unsigned DivSteps  = 16;

  // opcode carried in tuser
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } ksl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic probe_rd;
    logic probe_upd;
    logic rd_hi;
    logic rd_lo;
    logic check;
    logic div_step;
    logic out_load;
  } ksl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic up_valid;
    logic range_ok;
  } ksl_status_t;

endpackage

[rtl/ksl_datapath.sv]
`include "keyframe_segment_locate_unit_macros.svh"

module ksl_datapath #(
  parameter int MAX_KEYS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ksl_pkg::ksl_cmd_t               cmd,
  output ksl_pkg::ksl_status_t            status,
  input  logic                            cfg_valid,
  input  logic [ksl_pkg::CountW-1:0]      cfg_data,
  input  logic [ksl_pkg::InDataW-1:0]     in_tdata,
  input  logic                            in_tuser,
  output logic [ksl_pkg::OutDataW-1:0]    out_tdata
);
  import ksl_pkg::*;

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  // request fields
  logic [KeyIdxW-1:0]     in_key_index;
  logic signed [KeyW-1:0] in_key_value;
  logic signed [KeyW-1:0] in_frame;

  assign in_key_index = in_tdata[KeyIdxW-1:0];
  assign in_key_value = in_tdata[KeyIdxW+KeyW-1:KeyIdxW];
  assign in_frame     = in_tdata[KeyIdxW+2*KeyW-1:KeyIdxW+KeyW];

  logic [CountW-1:0]      key_count_r;
  logic [KeyW-1:0]        key_mem [MAX_KEYS];
  logic [KeyW-1:0]        rdata_r;
  logic signed [KeyW-1:0] frame_r;
  logic signed [KeyW-1:0] hi_r;
  logic [CW-1:0]          n_r;
  logic [CW-1:0]          first_r;
  logic [CW-1:0]          count_r;
  logic                   query_r;
  logic                   ok_r;
  logic [KeyW-1:0]        rem_r;
  logic [KeyW-1:0]        den_r;
  logic [AlphaW-1:0]      quo_r;
  logic [OutDataW-1:0]    out_data_r;

  // key count register, to be written only while idle (the block does not enforce it)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (cfg_valid) begin
      key_count_r <= cfg_data;
    end
  end

  // count clamped to the table depth
  logic [CW-1:0] n_eff;
  assign n_eff = (int'(key_count_r) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count_r);

  // search probe position
  logic [CW-1:0] half;
  logic [CW-1:0] probe;
  assign half  = count_r >> 1;
  assign probe = first_r + half;

  // table write on load requests
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  assign wr_en   = cmd.accept && (in_tuser == OpLoad) && (int'(in_key_index) < MAX_KEYS);
  assign wr_addr = IW'(in_key_index);

  // one read port, address picked by the controller step
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  assign rd_en = cmd.probe_rd || cmd.rd_hi || cmd.rd_lo;
  always_comb begin
    if (cmd.probe_rd) begin
      rd_addr = probe[IW-1:0];
    end else if (cmd.rd_hi) begin
      rd_addr = first_r[IW-1:0];
    end else begin
      rd_addr = IW'(first_r - CW'(1));
    end
  end

  // key table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= in_key_value;
    end
    if (rd_en) begin
      rdata_r <= key_mem[rd_addr];
    end
  end

  // bracket check and divider operands
  logic signed [KeyW-1:0] lo_key;
  logic [KeyW:0]          num_ext;
  logic [KeyW:0]          den_ext;
  assign lo_key  = $signed(rdata_r);
  assign num_ext = {frame_r[KeyW-1], frame_r} - {lo_key[KeyW-1], lo_key};
  assign den_ext = {hi_r[KeyW-1], hi_r} - {lo_key[KeyW-1], lo_key};

  // restoring divide step
  logic [KeyW:0] rem_sh;
  logic          rem_ge;
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_r};

  // search, fetch and divide registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      frame_r <= in_frame;
      n_r     <= n_eff;
      first_r <= '0;
      count_r <= (in_tuser == OpQuery) ? n_eff : '0;
      query_r <= (in_tuser == OpQuery);
      ok_r    <= 1'b0;
      quo_r   <= '0;
    end
    if (cmd.probe_upd) begin
      if (!(frame_r < $signed(rdata_r))) begin
        first_r <= probe + CW'(1);
        count_r <= count_r - half - CW'(1);
      end else begin
        count_r <= half;
      end
    end
    if (cmd.rd_lo) begin
      hi_r <= $signed(rdata_r);
    end
    if (cmd.check) begin
      ok_r  <= status.range_ok;
      rem_r <= num_ext[KeyW-1:0];
      den_r <= den_ext[KeyW-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? KeyW'(rem_sh - {1'b0, den_r}) : rem_sh[KeyW-1:0];
      quo_r <= {quo_r[AlphaW-2:0], rem_ge};
    end
  end

  // status back to the controller
  assign status.count_zero = (count_r == '0);
  assign status.up_valid   = (first_r != '0) && (first_r < n_r);
  assign status.range_ok   = (lo_key <= frame_r) && (frame_r < hi_r);

  // result packing into the output register
  logic [CountW-1:0] up_idx;
  logic [CountW-1:0] lo_idx;
  assign up_idx = query_r ? CountW'(first_r) : '0;
  assign lo_idx = query_r ? (up_idx - CountW'(1)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {1'b0, ok_r, (ok_r ? quo_r : AlphaW'(0)), lo_idx, up_idx};
    end
  end

  assign out_tdata = out_data_r;

  `KSL_ASSERT_NOW(a_probe_in_table, cmd.probe_rd, probe < n_r)
  `KSL_ASSERT_NOW(a_fetch_in_table, cmd.rd_hi, (first_r != '0) && (first_r < n_r))
  `KSL_ASSERT_NOW(a_rem_below_den, cmd.div_step, rem_r < den_r)

endmodule

[rtl/ksl_controller.sv]
`include "keyframe_segment_locate_unit_macros.svh"

module ksl_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output ksl_pkg::ksl_cmd_t    cmd,
  input  ksl_pkg::ksl_status_t status
);
  import ksl_pkg::*;

  localparam int DW = $clog2(DivSteps);

  ksl_state_t    state_r;
  ksl_state_t    state_nxt;
  logic [DW-1:0] div_cnt_r;
  logic          out_valid_r;
  logic          out_free;
  logic          accept;

  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser == OpQuery) ? ST_PROBE : ST_FINISH;
        end
      end
      ST_PROBE: begin
        state_nxt = status.count_zero ? ST_FETCH_HI : ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_PROBE;
      end
      ST_FETCH_HI: begin
        state_nxt = status.up_valid ? ST_FETCH_LO : ST_FINISH;
      end
      ST_FETCH_LO: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = status.range_ok ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        if (div_cnt_r == DW'(DivSteps - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_PROBE: begin
        cmd.probe_rd = !status.count_zero;
      end
      ST_CMP: begin
        cmd.probe_upd = 1'b1;
      end
      ST_FETCH_HI: begin
        cmd.rd_hi = status.up_valid;
      end
      ST_FETCH_LO: begin
        cmd.rd_lo = 1'b1;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // state, divide counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + DW'(1);
      end else begin
        div_cnt_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;

  `KSL_ASSERT_NOW(a_load_only_when_free, cmd.out_load, !out_valid_r || out_tready)
  `KSL_ASSERT_NEXT(a_one_request_at_a_time, accept, !in_tready)
  `KSL_ASSERT_NOW(a_div_full_length, (state_r == ST_DIV) && (state_nxt == ST_FINISH),
                  div_cnt_r == DW'(DivSteps - 1))

endmodule

[rtl/keyframe_segment_locate_unit.sv]
// keyframe segment locate unit
// channels: cfg_valid/cfg_ready/cfg_data writes key_count (always ready);
//   in_* carries load and query requests, in_tuser is the opcode
//   (0 loads key_value into slot key_index, 1 queries frame);
//   out_* carries one result per request.
// a query runs an upper-bound binary search over the first key_count
// keys, reads the two bracketing keys and divides (frame - lower key)
// by (upper key - lower key) into a 16-bit fraction, one bit a cycle.
// steps: a load goes straight to loading its result. a query runs P
//   search probes (at most ceil(log2(key_count + 1))), each a table read
//   and a compare, then fetches and checks the keys when both exist,
//   divides when the frame lies between them and loads the result. the
//   single read port of the key table splits each probe into read and
//   compare, and the divider is serial.
// one request is in work at a time; the next is taken once the result of
// the previous one sits in the output register, even if not yet taken.
// if out_tready stays low, the result holds and the unit stalls at the end
// of the following request.
// reset clears key_count, the controller and out_tvalid; key table entries
// keep whatever was written and read undefined until loaded.
module keyframe_segment_locate_unit #(
  parameter int MAX_KEYS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ksl_pkg::CountW-1:0]   cfg_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // key_index[5:0], key_value[37:6], frame[69:38], zero[71:70]
  input  logic [ksl_pkg::InDataW-1:0]  in_tdata,
  // opcode[0]
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // upper_index[6:0], lower_index[13:7], alpha[29:14], in_range[30], zero[31]
  output logic [ksl_pkg::OutDataW-1:0] out_tdata
);
  import ksl_pkg::*;

  ksl_cmd_t    cmd;
  ksl_status_t status;

  assign cfg_ready = 1'b1;

  // sequencing of search, fetch and divide
  ksl_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  // key table, search registers and divider
  ksl_datapath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule
